[hw/rtl/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  localparam int FIELD_W = 32;
  localparam int WIDE_W  = 64;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_ZDEN = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [WIDE_W-1:0] res_num;
    logic signed [WIDE_W-1:0] res_den;
    logic [1:0]               status;
  } res_t;

  // direct: result is final, no reduction needed
  typedef struct packed {
    logic              direct;
    logic [1:0]        status;
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] den;
  } entry_t;

endpackage
`default_nettype wire

[hw/rtl/rau_front.sv]
// Front end: takes a request, forms raw products and classifies the item.
`default_nettype none
module rau_front #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire rau_pkg::req_t  req,
  output logic                push,
  input  wire logic           full,
  output rau_pkg::entry_t     entry
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0] state;
  logic [1:0] step;
  logic [1:0] op;
  logic signed [W-1:0] an, ad, bn, bd;
  logic [WIDE_W-1:0] m0, m1, m2;

  logic signed [W-1:0]   ma, mb;
  logic signed [2*W-1:0] prod;
  logic signed [WIDE_W-1:0] prod_ext;

  always_comb begin
    case (step)
      2'd0: begin
        ma = an;
        mb = (op == OP_MUL) ? bn : bd;
      end
      2'd1: begin
        ma = ad;
        mb = (op == OP_MUL) ? bd : bn;
      end
      default: begin
        ma = ad;
        mb = bd;
      end
    endcase
  end

  assign prod     = ma * mb;
  assign prod_ext = WIDE_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= req.req_type;
            an    <= req.a_num[W-1:0];
            ad    <= req.a_den[W-1:0];
            bn    <= req.b_num[W-1:0];
            bd    <= req.b_den[W-1:0];
            step  <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          case (step)
            2'd0:    m0 <= prod_ext;
            2'd1:    m1 <= prod_ext;
            default: m2 <= prod_ext;
          endcase
          if (step == 2'd2) begin
            state <= S_PUSH;
          end else begin
            step <= step + 2'd1;
          end
        end
        S_PUSH: begin
          if (!full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [WIDE_W:0] p_ext, q_ext, sum;
  logic addsub, sum_ovf, zden;
  logic [WIDE_W-1:0] num, den;

  always_comb begin
    p_ext   = {m0[WIDE_W-1], m0};
    q_ext   = {m1[WIDE_W-1], m1};
    sum     = (op == OP_SUB) ? (p_ext - q_ext) : (p_ext + q_ext);
    addsub  = (op == OP_ADD) || (op == OP_SUB);
    sum_ovf = addsub && (sum[WIDE_W] != sum[WIDE_W-1]);
    zden    = (ad == '0) || (bd == '0);
    num     = addsub ? sum[WIDE_W-1:0] : m0;
    den     = addsub ? m2 : m1;
    entry.direct = 1'b1;
    entry.status = ST_OK;
    entry.num    = num;
    entry.den    = den;
    if ((op == OP_DIV) && (bn == '0)) begin
      entry.status = ST_DIV0;
      entry.num    = '0;
      entry.den    = WIDE_W'(1);
    end else if (sum_ovf) begin
      entry.status = zden ? ST_ZDEN : ST_OVF;
    end else if (zden) begin
      entry.status = ST_ZDEN;
    end else begin
      entry.direct = 1'b0;
    end
  end

  assign push      = (state == S_PUSH) && !full;
  assign req_stall = (state != S_IDLE);

  a_mul_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && step == 2'd2) |=> (state == S_PUSH))
    else $error("front left multiply phase early");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid) |=> (state == S_MUL && step == 2'd0))
    else $error("accepted beat did not start products");
  a_push_state: assert property (@(posedge clk) disable iff (rst)
    push |-> (state == S_PUSH))
    else $error("push outside push state");

endmodule
`default_nettype wire

[hw/rtl/rau_queue.sv]
// Two-entry queue between front end and reduction back end.
`default_nettype none
module rau_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rau_pkg::entry_t wdata,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output rau_pkg::entry_t      rdata
);
  import rau_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slots[rd_ptr];

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue underrun");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

endmodule
`default_nettype wire

[hw/rtl/rau_back.sv]
// Back end: binary GCD, two exact divides, sign fix and output register.
`default_nettype none
module rau_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            empty,
  input  wire rau_pkg::entry_t entry,
  output logic                 pop,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output rau_pkg::res_t        res
);
  import rau_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_GCD  = 3'd1;
  localparam logic [2:0] B_DIVN = 3'd2;
  localparam logic [2:0] B_DIVD = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]        state;
  logic [WIDE_W-1:0] raw_num, un, ud, x, y, g, dq, rn;
  logic [WIDE_W:0]   rem;
  logic [5:0]        k, cnt;
  logic              neg;

  logic [WIDE_W-1:0] e_un, e_ud;
  logic [WIDE_W:0]   rem_sh, rem_nx;
  logic              ge;
  logic [WIDE_W-1:0] q_last;

  always_comb begin
    e_un   = entry.num[WIDE_W-1] ? (~entry.num + 1'b1) : entry.num;
    e_ud   = entry.den[WIDE_W-1] ? (~entry.den + 1'b1) : entry.den;
    rem_sh = {rem[WIDE_W-1:0], dq[WIDE_W-1]};
    ge     = rem_sh >= {1'b0, g};
    rem_nx = ge ? (rem_sh - {1'b0, g}) : rem_sh;
    q_last = {dq[WIDE_W-2:0], ge};
  end

  assign pop = (state == B_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            raw_num <= entry.num;
            un      <= e_un;
            ud      <= e_ud;
            neg     <= entry.num[WIDE_W-1] ^ entry.den[WIDE_W-1];
            x       <= e_un;
            y       <= e_ud;
            k       <= '0;
            if (entry.direct) begin
              res   <= '{res_num: entry.num, res_den: entry.den, status: entry.status};
              state <= B_OUT;
            end else if (e_un == '0) begin
              res   <= '{res_num: '0, res_den: WIDE_W'(1), status: ST_OK};
              state <= B_OUT;
            end else begin
              state <= B_GCD;
            end
          end
        end
        B_GCD: begin
          if (x == '0) begin
            g     <= y << k;
            dq    <= un;
            rem   <= '0;
            cnt   <= '0;
            state <= B_DIVN;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 6'd1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x >= y) begin
            x <= x - y;
          end else begin
            y <= y - x;
          end
        end
        B_DIVN: begin
          rem <= rem_nx;
          dq  <= q_last;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            rn    <= q_last;
            dq    <= ud;
            rem   <= '0;
            cnt   <= '0;
            state <= B_DIVD;
          end
        end
        B_DIVD: begin
          rem <= rem_nx;
          dq  <= q_last;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            if (!neg && rn[WIDE_W-1]) begin
              res <= '{res_num: raw_num, res_den: (~q_last + 1'b1), status: ST_OVF};
            end else begin
              res <= '{res_num: (neg ? (~rn + 1'b1) : rn), res_den: q_last,
                       status: ST_OK};
            end
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (!res_stall) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign res_valid = (state == B_OUT);

  a_ok_den_pos: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_OK) |-> (!res.res_den[WIDE_W-1] && res.res_den != '0))
    else $error("ok result with non-positive denominator");
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIVN) |-> (g != '0))
    else $error("zero divisor in reduction");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != B_DIVN && state != B_DIVD))
    else $error("pop did not start from idle");

endmodule
`default_nettype wire

[hw/rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: adds, subtracts, multiplies, divides fractions with reduction.
// Front end: one request at a time (accept, three products on one multiplier, classify/push).
// Back end: direct results (zero denominator, overflow, divide by zero) skip the reduction;
// reduced results go through binary GCD steps plus two bit-serial exact divides,
// one entry at a time; the back end sets the sustained rate.
// Synchronous active-high reset empties the queue and returns both ends to idle.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire rau_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_stall,
  output rau_pkg::res_t      res
);
  import rau_pkg::*;

  entry_t q_wdata, q_rdata;
  logic   q_push, q_full, q_pop, q_empty;

  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst, .req_valid, .req_stall, .req,
    .push(q_push), .full(q_full), .entry(q_wdata)
  );

  rau_queue u_queue (
    .clk, .rst, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  rau_back u_back (
    .clk, .rst, .empty(q_empty), .entry(q_rdata), .pop(q_pop),
    .res_valid, .res_stall, .res
  );

endmodule
`default_nettype wire

[verif/rational_arithmetic_unit_tb.sv]
// Testbench for the rational arithmetic unit: random and directed fractions, scoreboard check.
`default_nettype none
module rational_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam int HOLD_CYCLES = 1500;
  localparam int LIMIT_CYCLES = 3_000_000;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  int send_idle = 20;
  int recv_idle = 65;
  int sent = 0;

  rational_arithmetic_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic res_t reduce_fraction(req_t r);
    res_t o;
    longint an, ad, bn, bd, p, q, num, den;
    longint unsigned un, ud, g, rn, rd;
    logic neg;
    an = longint'(r.a_num);
    ad = longint'(r.a_den);
    bn = longint'(r.b_num);
    bd = longint'(r.b_den);
    if (r.req_type == OP_DIV && bn == 0) begin
      o.res_num = 0; o.res_den = 1; o.status = ST_DIV0;
      return o;
    end
    den = ad * bd;
    case (r.req_type) inside
      OP_ADD, OP_SUB: begin
        p = an * bd;
        q = ad * bn;
        if (r.req_type == OP_SUB) q = -q;
        num = p + q;
        if (ad != 0 && bd != 0 && p[63] == q[63] && num[63] != p[63]) begin
          o.res_num = num; o.res_den = den; o.status = ST_OVF;
          return o;
        end
      end
      OP_MUL: num = an * bn;
      default: begin
        num = an * bd;
        den = ad * bn;
      end
    endcase
    if (ad == 0 || bd == 0) begin
      o.res_num = num; o.res_den = den; o.status = ST_ZDEN;
      return o;
    end
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    g = gcd64(un, ud);
    if (g == 0) g = 1;
    rn = un / g;
    rd = ud / g;
    if (rn == 0) begin
      o.res_num = 0; o.res_den = 1; o.status = ST_OK;
      return o;
    end
    neg = (num < 0) != (den < 0);
    if (!neg && rn > 64'h7fff_ffff_ffff_ffff) begin
      o.res_num = num; o.res_den = -rd; o.status = ST_OVF;
      return o;
    end
    o.res_num = neg ? -rn : rn;
    o.res_den = rd;
    o.status = ST_OK;
    return o;
  endfunction

  class rational_scoreboard;
    res_t expected_q[$];
    int errors = 0;

    function void note_request(req_t r);
      expected_q.push_back(reduce_fraction(r));
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat num=%0d den=%0d status=%0d",
               got.res_num, got.res_den, got.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.res_num !== e.res_num) begin
        $error("res_num expected %0d actual %0d", e.res_num, got.res_num);
        errors++;
      end
      if (got.res_den !== e.res_den) begin
        $error("res_den expected %0d actual %0d", e.res_den, got.res_den);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  rational_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: check, random stall, one long hold-off mid run
  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) sb.check_result(res);
      if (!hold_done && sent >= 900) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  task automatic send_beat(req_t r);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    sent++;
  endtask

  task automatic send_fracs(logic [1:0] op, int an, int ad, int bn, int bd);
    req_t r;
    r.req_type = op;
    r.a_num = an; r.a_den = ad; r.b_num = bn; r.b_den = bd;
    send_beat(r);
  endtask

  function automatic logic [31:0] pick_field();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4, 5: return $urandom_range(40) - 20;
      6: return 0;
      7: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'd1;
        endcase
      end
      default: return ($urandom_range(60) - 30) << $urandom_range(24);
    endcase
  endfunction

  task automatic send_random();
    req_t r;
    r.req_type = 2'($urandom_range(3));
    r.a_num = pick_field();
    r.a_den = pick_field();
    r.b_num = pick_field();
    r.b_den = pick_field();
    send_beat(r);
  endtask

  localparam int MIN32 = 32'h8000_0000;
  localparam int MAX32 = 32'h7fff_ffff;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_fracs(OP_ADD, 1, 2, 1, 3);
    send_fracs(OP_SUB, 1, 2, 1, 3);
    send_fracs(OP_MUL, -2, 4, 3, -9);
    send_fracs(OP_DIV, 3, 4, -9, 8);
    send_fracs(OP_DIV, 5, 7, 0, 3);
    send_fracs(OP_DIV, 5, 0, 0, 0);
    send_fracs(OP_ADD, 5, 0, 1, 3);
    send_fracs(OP_MUL, 5, 3, 1, 0);
    send_fracs(OP_ADD, MIN32, MIN32, MIN32, MIN32);
    send_fracs(OP_SUB, MIN32, MIN32, MAX32, MIN32);
    send_fracs(OP_SUB, MAX32, MIN32, MIN32, MIN32);
    send_fracs(OP_ADD, MIN32, 0, MIN32, MIN32);
    send_fracs(OP_SUB, 3, 5, 3, 5);
    send_fracs(OP_MUL, 0, -7, 4, 9);
    send_fracs(OP_MUL, MAX32, MAX32, MAX32, MAX32);
    send_fracs(OP_MUL, MIN32, MAX32, MIN32, MAX32);
    send_fracs(OP_DIV, MIN32, -1, MIN32, -1);
    send_fracs(OP_DIV, MAX32, MIN32, 1, -1);
    send_fracs(OP_ADD, -1, -1, -1, -1);
    send_fracs(OP_MUL, 6, -4, 10, 15);

    repeat (560) send_random();
    send_idle = 65;
    recv_idle = 20;
    repeat (560) send_random();
    send_idle = 0;
    recv_idle = 0;
    repeat (560) send_random();
    req_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
hw/rtl/rau_pkg.sv
hw/rtl/rau_front.sv
hw/rtl/rau_queue.sv
hw/rtl/rau_back.sv
hw/rtl/rational_arithmetic_unit.sv
verif/rational_arithmetic_unit_tb.sv
